// ===== design/csc_pkg.sv =====
// Package for the conveyor segment controller: opcodes, field widths and the
// item and result structures shared by the interfaces, the core and the top level.
// No dependencies.
package csc_pkg;

    localparam int unsigned OPCODE_W  = 3;
    localparam int unsigned FORCE_W   = 8;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned TICKS_W   = 16;

    localparam logic [TICKS_W-1:0] TRANSIT_TICKS_RESET = 16'd1000;
    localparam logic [TICKS_W-1:0] IDLE_TICKS_MAX      = 16'hFFFF;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK        = 3'd0,
        OP_ENTRY       = 3'd1,
        OP_EXIT        = 3'd2,
        OP_FORCE_MOTOR = 3'd3,
        OP_FORCE_COUNT = 3'd4,
        OP_RESUME      = 3'd5
    } t_opcode;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic                sensor_level;
        logic [FORCE_W-1:0]  force_value;
    } t_in_item;

    typedef struct packed {
        logic               motor_running;
        logic [COUNT_W-1:0] boxes_now;
        logic               jam_alarm;
        logic               stray_box;
        logic               held;
    } t_result;

endpackage

// ===== design/csc_if.sv =====
// Channel interfaces of the conveyor segment controller: event requests in,
// status results out and the transit_ticks write channel.
// Depends on csc_pkg.
interface csc_in_if;
    logic                           valid;
    logic                           ready;
    logic [csc_pkg::OPCODE_W-1:0]   opcode;
    logic                           sensor_level;
    logic [csc_pkg::FORCE_W-1:0]    force_value;

    modport source(output valid, output opcode, output sensor_level, output force_value,
                   input ready);
    modport sink(input valid, input opcode, input sensor_level, input force_value,
                 output ready);
endinterface

interface csc_out_if;
    logic                           valid;
    logic                           ready;
    logic                           motor_running;
    logic [csc_pkg::COUNT_W-1:0]    boxes_now;
    logic                           jam_alarm;
    logic                           stray_box;
    logic                           held;

    modport source(output valid, output motor_running, output boxes_now, output jam_alarm,
                   output stray_box, output held, input ready);
    modport sink(input valid, input motor_running, input boxes_now, input jam_alarm,
                 input stray_box, input held, output ready);
endinterface

interface csc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [csc_pkg::TICKS_W-1:0]    data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== design/csc_core.sv =====
// Segment state (box count, motor, idle timer, hold flag) and its per-request
// update; the result reflects the state after the request.
// Depends on csc_pkg.
module csc_core #(
    parameter logic [csc_pkg::COUNT_W-1:0] BOX_CAP = 8'd255
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  csc_pkg::t_in_item             i_item,
    input  logic [csc_pkg::TICKS_W-1:0]   i_transit_ticks,
    output csc_pkg::t_result              o_result
);

    logic [csc_pkg::COUNT_W-1:0] r_box_count, n_box_count;
    logic                        r_motor, n_motor;
    logic [csc_pkg::TICKS_W-1:0] r_idle_ticks, n_idle_ticks;
    logic                        r_held, n_held;
    logic [csc_pkg::TICKS_W-1:0] w_idle_inc;
    logic                        w_jam;
    logic                        w_stray;

    always_comb begin
        n_box_count  = r_box_count;
        n_motor      = r_motor;
        n_idle_ticks = r_idle_ticks;
        n_held       = r_held;
        w_jam        = 1'b0;
        w_stray      = 1'b0;
        w_idle_inc   = (r_idle_ticks == csc_pkg::IDLE_TICKS_MAX) ? r_idle_ticks
                                                                 : r_idle_ticks + 16'd1;
        case (csc_pkg::t_opcode'(i_item.opcode))
            csc_pkg::OP_TICK: begin
                if (!r_held && r_motor) begin
                    n_idle_ticks = w_idle_inc;
                    // Reaching the bound restarts the timer, so a jam repeats only
                    // after another full bound.
                    if (w_idle_inc >= i_transit_ticks) begin
                        n_idle_ticks = '0;
                        if (r_box_count != '0) begin
                            w_jam = 1'b1;
                        end else begin
                            n_motor = 1'b0;
                        end
                    end
                end
            end
            csc_pkg::OP_ENTRY: begin
                if (!r_held && i_item.sensor_level) begin
                    n_motor      = 1'b1;
                    n_idle_ticks = '0;
                    if (r_box_count < BOX_CAP) begin
                        n_box_count = r_box_count + 8'd1;
                    end
                end
            end
            csc_pkg::OP_EXIT: begin
                if (!r_held && !i_item.sensor_level) begin
                    if (r_box_count != '0) begin
                        n_box_count = r_box_count - 8'd1;
                    end else begin
                        w_stray = 1'b1;
                    end
                    n_idle_ticks = '0;
                end
            end
            csc_pkg::OP_FORCE_MOTOR: begin
                n_held  = 1'b1;
                n_motor = i_item.force_value[0];
            end
            csc_pkg::OP_FORCE_COUNT: begin
                n_held      = 1'b1;
                n_box_count = (i_item.force_value > BOX_CAP) ? BOX_CAP : i_item.force_value;
            end
            csc_pkg::OP_RESUME: begin
                n_held = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_count  <= '0;
            r_motor      <= 1'b0;
            r_idle_ticks <= '0;
            r_held       <= 1'b0;
        end else if (i_fire) begin
            r_box_count  <= n_box_count;
            r_motor      <= n_motor;
            r_idle_ticks <= n_idle_ticks;
            r_held       <= n_held;
        end
    end

    always_comb begin
        o_result.motor_running = n_motor;
        o_result.boxes_now     = n_box_count;
        o_result.jam_alarm     = w_jam;
        o_result.stray_box     = w_stray;
        o_result.held          = n_held;
    end

endmodule

// ===== design/conveyor_segment_controller_top.sv =====
// Top level of the conveyor segment controller: request register, result
// register, transit_ticks register and the segment core.
// Depends on csc_pkg, csc_if (csc_in_if, csc_out_if, csc_cfg_if) and csc_core.
//
//  channel  | direction | carries
//  ---------+-----------+------------------------------------------------------
//  i_cfg    | in        | transit_ticks write data
//  i_in     | in        | opcode, sensor_level, force_value
//  o_out    | out       | motor_running, boxes_now, jam_alarm, stray_box, held
//
// One request per cycle sustained while results are taken. An accepted request waits in
// the request register, then its result is held in the result register until taken;
// it moves on once the result register is free or being emptied.
// The request register lets a new request in while a result waits to be taken.
// Reset is synchronous, active low: the segment is empty, the motor off, not held,
// and transit_ticks returns to 1000. The write channel is always ready.
module conveyor_segment_controller_top #(
    parameter int unsigned COUNT_MAX = 255
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    csc_cfg_if.sink           i_cfg,
    csc_in_if.sink            i_in,
    csc_out_if.source         o_out
);

    localparam int unsigned BoxCapInt = (COUNT_MAX < 255) ? COUNT_MAX : 255;
    localparam logic [csc_pkg::COUNT_W-1:0] BOX_CAP = BoxCapInt[csc_pkg::COUNT_W-1:0];

    logic [csc_pkg::TICKS_W-1:0] r_transit_ticks;
    logic                        r_in_valid;
    csc_pkg::t_in_item           r_in_item;
    logic                        r_out_valid;
    csc_pkg::t_result            r_out_result;
    csc_pkg::t_result            w_result;
    logic                        w_out_free;
    logic                        w_fire;
    logic                        w_in_accept;

    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_fire      = r_in_valid && w_out_free;
    assign i_in.ready  = !r_in_valid || w_fire;
    assign w_in_accept = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transit_ticks <= csc_pkg::TRANSIT_TICKS_RESET;
        end else if (i_cfg.valid) begin
            r_transit_ticks <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_item.opcode       <= i_in.opcode;
            r_in_item.sensor_level <= i_in.sensor_level;
            r_in_item.force_value  <= i_in.force_value;
        end
    end

    csc_core #(
        .BOX_CAP(BOX_CAP)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_item         (r_in_item),
        .i_transit_ticks(r_transit_ticks),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_result <= w_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.motor_running = r_out_result.motor_running;
    assign o_out.boxes_now     = r_out_result.boxes_now;
    assign o_out.jam_alarm     = r_out_result.jam_alarm;
    assign o_out.stray_box     = r_out_result.stray_box;
    assign o_out.held          = r_out_result.held;

    // A jam is only reported with boxes on the belt, and the motor keeps running.
    a_jam_needs_boxes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.jam_alarm) |-> (o_out.motor_running && o_out.boxes_now != '0))
        else $error("jam reported without boxes or with motor off");

    // Both pulses come from different requests and never share a result.
    a_pulses_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.jam_alarm && o_out.stray_box))
        else $error("jam and stray box in one result");

    a_count_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.boxes_now <= BOX_CAP))
        else $error("box count above cap");

    // With both registers full and the result stalled, no request may enter.
    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("request accepted with pipeline full");

endmodule

// ===== verif/tb_conveyor_segment_controller_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for conveyor_segment_controller_top: directed and random event
// requests, a status predictor in a scoreboard class, and random idling on both channels.
// Depends on csc_pkg, csc_if and the conveyor segment controller RTL.
module tb_conveyor_segment_controller_top;

    localparam int unsigned COUNT_MAX      = 255;
    localparam int unsigned BOX_CAP        = (COUNT_MAX < 255) ? COUNT_MAX : 255;
    localparam int unsigned PHASES         = 9;
    localparam int unsigned PHASE_REQUESTS = 160;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned REPORT_LIMIT   = 10;

    // Opcodes the block must ignore.
    localparam logic [csc_pkg::OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [csc_pkg::OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

    class segment_status_board;
        logic [csc_pkg::COUNT_W-1:0] box_count;
        logic                        motor_cmd;
        logic [csc_pkg::TICKS_W-1:0] idle_ticks;
        logic                        held;
        logic [csc_pkg::TICKS_W-1:0] transit_ticks;
        csc_pkg::t_result            status_due[$];
        int unsigned                 failures;

        function new();
            box_count     = '0;
            motor_cmd     = 1'b0;
            idle_ticks    = '0;
            held          = 1'b0;
            transit_ticks = csc_pkg::TRANSIT_TICKS_RESET;
            failures      = 0;
        endfunction

        function void set_bound(logic [csc_pkg::TICKS_W-1:0] bound);
            transit_ticks = bound;
        endfunction

        function int pending();
            return status_due.size();
        endfunction

        function csc_pkg::t_result advance_segment(csc_pkg::t_in_item req);
            csc_pkg::t_result st;
            st = '0;
            case (req.opcode)
                csc_pkg::OP_TICK: begin
                    if (!held && motor_cmd) begin
                        if (idle_ticks != csc_pkg::IDLE_TICKS_MAX)
                            idle_ticks = idle_ticks + 1'b1;
                        if (idle_ticks >= transit_ticks) begin
                            idle_ticks = '0;
                            if (box_count != 0) st.jam_alarm = 1'b1;
                            else motor_cmd = 1'b0;
                        end
                    end
                end
                csc_pkg::OP_ENTRY: begin
                    if (!held && req.sensor_level) begin
                        motor_cmd  = 1'b1;
                        idle_ticks = '0;
                        if (box_count < BOX_CAP) box_count = box_count + 1'b1;
                    end
                end
                csc_pkg::OP_EXIT: begin
                    if (!held && !req.sensor_level) begin
                        if (box_count != 0) box_count = box_count - 1'b1;
                        else st.stray_box = 1'b1;
                        idle_ticks = '0;
                    end
                end
                csc_pkg::OP_FORCE_MOTOR: begin
                    held      = 1'b1;
                    motor_cmd = req.force_value[0];
                end
                csc_pkg::OP_FORCE_COUNT: begin
                    held      = 1'b1;
                    box_count = (req.force_value > BOX_CAP) ? BOX_CAP[csc_pkg::COUNT_W-1:0]
                                                            : req.force_value;
                end
                csc_pkg::OP_RESUME: begin
                    held = 1'b0;
                end
                default: begin
                end
            endcase
            st.motor_running = motor_cmd;
            st.boxes_now     = box_count;
            st.held          = held;
            return st;
        endfunction

        function void note_request(csc_pkg::t_in_item req);
            status_due.push_back(advance_segment(req));
        endfunction

        function string show(csc_pkg::t_result st);
            return $sformatf("motor=%0b boxes=%0d jam=%0b stray=%0b held=%0b",
                             st.motor_running, st.boxes_now, st.jam_alarm, st.stray_box,
                             st.held);
        endfunction

        function void check_status(csc_pkg::t_result got);
            csc_pkg::t_result want;
            if (status_due.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("status with no request outstanding: %s", show(got));
                return;
            end
            want = status_due.pop_front();
            if (got.motor_running !== want.motor_running || got.boxes_now !== want.boxes_now ||
                got.jam_alarm !== want.jam_alarm || got.stray_box !== want.stray_box ||
                got.held !== want.held) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("status differs: expected %s, got %s", show(want), show(got));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    csc_in_if  in_ch();
    csc_out_if out_ch();
    csc_cfg_if cfg_ch();

    conveyor_segment_controller_top #(
        .COUNT_MAX(COUNT_MAX)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    segment_status_board board = new();

    int unsigned       send_gap_pct;
    int unsigned       stall_pct;
    int unsigned       stall_cycles;
    bit                hold_guess;
    csc_pkg::t_in_item seen_req;
    csc_pkg::t_result  seen_status;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Everything is sampled at the rising edge, before the block's own updates land.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) board.set_bound(cfg_ch.data);
            if (in_ch.valid && in_ch.ready) begin
                seen_req.opcode       = in_ch.opcode;
                seen_req.sensor_level = in_ch.sensor_level;
                seen_req.force_value  = in_ch.force_value;
                board.note_request(seen_req);
            end
            if (out_ch.valid && out_ch.ready) begin
                seen_status.motor_running = out_ch.motor_running;
                seen_status.boxes_now     = out_ch.boxes_now;
                seen_status.jam_alarm     = out_ch.jam_alarm;
                seen_status.stray_box     = out_ch.stray_box;
                seen_status.held          = out_ch.held;
                board.check_status(seen_status);
            end
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("conveyor_segment_controller_top: mismatch");
        $finish;
    end

    task automatic set_idling(input int unsigned mode);
        case (mode)
            0: begin
                send_gap_pct = 19;
                stall_pct    = 71;
            end
            1: begin
                send_gap_pct = 71;
                stall_pct    = 19;
            end
            default: begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end
        endcase
    endtask

    // Entered just after a falling edge; returns at the falling edge after acceptance
    // with valid still high, so back-to-back requests need no gap.
    task automatic send_request(input logic [csc_pkg::OPCODE_W-1:0] op, input logic level,
                                input logic [csc_pkg::FORCE_W-1:0] value);
        while ($urandom_range(99) < send_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= op;
        in_ch.sensor_level <= level;
        in_ch.force_value  <= value;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain_segment();
        in_ch.valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_bound(input logic [csc_pkg::TICKS_W-1:0] bound);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= bound;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly ticks and sensor edges that the block acts on, with overrides and
    // ignored levels mixed in; a held segment is usually resumed soon.
    task automatic random_request();
        int unsigned                  roll;
        logic [csc_pkg::OPCODE_W-1:0] op;
        logic                         level;
        logic [csc_pkg::FORCE_W-1:0]  value;
        roll  = $urandom_range(99);
        level = 1'($urandom_range(1));
        value = 8'($urandom_range(255));
        if (hold_guess && roll < 60) op = csc_pkg::OP_RESUME;
        else if (roll < 44) op = csc_pkg::OP_TICK;
        else if (roll < 64) op = csc_pkg::OP_ENTRY;
        else if (roll < 84) op = csc_pkg::OP_EXIT;
        else if (roll < 88) op = csc_pkg::OP_FORCE_MOTOR;
        else if (roll < 92) op = csc_pkg::OP_FORCE_COUNT;
        else if (roll < 97) op = csc_pkg::OP_RESUME;
        else op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
        if (op == csc_pkg::OP_ENTRY) level = ($urandom_range(99) < 85);
        if (op == csc_pkg::OP_EXIT) level = ($urandom_range(99) >= 85);
        if (op == csc_pkg::OP_FORCE_COUNT && $urandom_range(99) < 30)
            value = 8'($urandom_range(255, 240));
        if (op == csc_pkg::OP_FORCE_MOTOR || op == csc_pkg::OP_FORCE_COUNT) hold_guess = 1'b1;
        if (op == csc_pkg::OP_RESUME) hold_guess = 1'b0;
        send_request(op, level, value);
    endtask

    initial begin
        logic [csc_pkg::TICKS_W-1:0] bounds[PHASES];
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.opcode        = csc_pkg::OP_TICK;
        in_ch.sensor_level  = 1'b0;
        in_ch.force_value   = '0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;
        hold_guess          = 1'b0;
        set_idling(0);
        bounds = '{16'd3, 16'd0, 16'hFFFF, 16'd1, 16'd17, 16'd0, 16'd1000, 16'd0, 16'd6};
        bounds[5] = 16'($urandom_range(40, 2));
        bounds[7] = 16'($urandom_range(65535, 0));

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset bound: ignored levels, a stray exit, overrides while held, the count cap.
        send_request(csc_pkg::OP_ENTRY, 1'b0, 8'h00);
        send_request(csc_pkg::OP_EXIT, 1'b0, 8'h00);
        send_request(csc_pkg::OP_ENTRY, 1'b1, 8'h00);
        send_request(csc_pkg::OP_EXIT, 1'b1, 8'h00);
        send_request(csc_pkg::OP_TICK, 1'b0, 8'h00);
        send_request(OP_SPARE_6, 1'b1, 8'hFF);
        send_request(OP_SPARE_7, 1'b0, 8'h00);
        send_request(csc_pkg::OP_FORCE_COUNT, 1'b0, 8'hFF);
        send_request(csc_pkg::OP_ENTRY, 1'b1, 8'h00);
        send_request(csc_pkg::OP_TICK, 1'b0, 8'h00);
        send_request(csc_pkg::OP_EXIT, 1'b0, 8'h00);
        send_request(csc_pkg::OP_FORCE_MOTOR, 1'b1, 8'hFE);
        send_request(csc_pkg::OP_FORCE_MOTOR, 1'b0, 8'h01);
        send_request(csc_pkg::OP_RESUME, 1'b0, 8'h00);
        send_request(csc_pkg::OP_RESUME, 1'b1, 8'hFF);
        send_request(csc_pkg::OP_ENTRY, 1'b1, 8'h00);
        send_request(csc_pkg::OP_EXIT, 1'b0, 8'h00);
        drain_segment();

        // Bound of one: a jam with boxes present, then the motor stopping when empty.
        write_bound(16'd1);
        send_request(csc_pkg::OP_TICK, 1'b0, 8'h00);
        send_request(csc_pkg::OP_FORCE_COUNT, 1'b1, 8'h00);
        send_request(csc_pkg::OP_RESUME, 1'b0, 8'h00);
        send_request(csc_pkg::OP_TICK, 1'b0, 8'h00);
        send_request(csc_pkg::OP_TICK, 1'b1, 8'h00);
        drain_segment();

        // Zero bound is reached on every tick while the motor runs.
        write_bound(16'd0);
        send_request(csc_pkg::OP_ENTRY, 1'b1, 8'h00);
        send_request(csc_pkg::OP_TICK, 1'b0, 8'h00);
        send_request(csc_pkg::OP_EXIT, 1'b0, 8'h00);
        send_request(csc_pkg::OP_TICK, 1'b0, 8'h00);

        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            drain_segment();
            write_bound(bounds[phase]);
            set_idling(phase / 3);
            repeat (PHASE_REQUESTS) random_request();
        end
        drain_segment();
        repeat (6) @(negedge i_clk);

        if (board.failures == 0 && board.pending() == 0)
            $display("conveyor_segment_controller_top: match");
        else
            $display("conveyor_segment_controller_top: mismatch");
        $finish;
    end

endmodule
